// File: rtl/core/inu_pkg.sv
`default_nettype none

package inu_pkg;

  // Source frame geometry and display limits
  localparam int SRC_WIDTH     = 512;
  localparam int SRC_HEIGHT    = 384;
  localparam int MAX_DISPLAY_W = 1920;
  localparam int MAX_DISPLAY_H = 1080;

  localparam int FRAME_SIZE = SRC_WIDTH * SRC_HEIGHT;
  localparam int FRAME_AW   = $clog2(FRAME_SIZE);

  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);
  localparam int RGB_W     = 24;
  localparam int IDX_W     = 8;

  // Field and register widths
  localparam int COORD_W    = 11;
  localparam int SRC_ADDR_W = 18;
  localparam int REQ_W      = 2;
  localparam int IN_DATA_W  = 80;
  localparam int ARGB_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // Divider: quotient is below the source size, one quotient bit per stage
  localparam int SRC_MAX   = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
  localparam int DIV_STEPS = $clog2(SRC_MAX);
  localparam int DIV_DW    = COORD_W + $clog2(SRC_MAX + 1);

  // Result queue: deep enough for every read in flight
  localparam int FIFO_AW    = $clog2(DIV_STEPS + 8);
  localparam int FIFO_DEPTH = 2 ** FIFO_AW;

  localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_PAL_WR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PIX_WR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_DISP_W  = 2'd0;
  localparam logic [1:0] REG_DISP_H  = 2'd1;
  localparam logic [1:0] REG_INSET_W = 2'd2;
  localparam logic [1:0] REG_INSET_H = 2'd3;

  // Register reset values
  localparam logic [COORD_W-1:0] RST_DISP_W  = 11'd1280;
  localparam logic [COORD_W-1:0] RST_DISP_H  = 11'd720;
  localparam logic [COORD_W-1:0] RST_INSET_W = 11'd1152;
  localparam logic [COORD_W-1:0] RST_INSET_H = 11'd648;

  // Input tdata layout, last field in the lowest bits
  typedef struct packed {
    logic [COORD_W-1:0]    disp_y;
    logic [COORD_W-1:0]    disp_x;
    logic [IDX_W-1:0]      color_index;
    logic [SRC_ADDR_W-1:0] src_address;
    logic [7:0]            blue;
    logic [7:0]            green;
    logic [7:0]            red;
    logic [7:0]            palette_slot;
  } in_data_t;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    in_data_t         data;
  } in_beat_t;

  // Per-axis placement of the picture rectangle
  typedef struct packed {
    logic [COORD_W-1:0] off;
    logic [COORD_W-1:0] w;
    logic               nz;
  } axis_cfg_t;

  // Control and write payload that travels with every beat
  typedef struct packed {
    logic [REQ_W-1:0]      kind;
    logic                  in_rect;
    logic [SRC_ADDR_W-1:0] waddr;
    logic [RGB_W-1:0]      wdata;
  } ctl_t;

  typedef struct packed {
    ctl_t                 ctl;
    logic [DIV_DW-1:0]    rem_x;
    logic [DIV_DW-1:0]    rem_y;
    logic [DIV_STEPS-1:0] q_x;
    logic [DIV_STEPS-1:0] q_y;
  } div_t;

  typedef struct packed {
    logic [ARGB_W-1:0] argb;
    logic              in_picture;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/inu_ram.sv
`default_nettype none

module inu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/indexed_nearest_upscaler_top.sv
`default_nettype none

// Palette-indexed nearest-neighbor upscaler.
// Input channel (in_*): one beat per request. in_tuser selects the kind: palette
// write, source pixel write or display pixel read. Writes give no result beat;
// every read gives exactly one result beat on out_*, in request order.
// Results: out_tdata carries opaque ARGB inside the centered picture rectangle
// and zero in the border; out_tuser flags a pixel inside the rectangle.
// Registers (cfg_*, APB, byte address 4*i): display width, display height,
// inset width, inset height. Write them only while no read is outstanding.
// Throughput: one beat per cycle while in_tready is high, reads and writes mixed freely.
// Divider: pipelined, one quotient bit a stage. Writes land in the frame and palette
// memories at the same pipeline stage where reads fetch them, so order is kept.
// Stall: results queue in a FIFO_DEPTH deep output queue; in_tready drops when
// that many reads are outstanding, and the pipeline itself never stalls.
// Reset: clears the pipeline, the output queue and the registers to their
// defaults; frame and palette contents are undefined until written.

module indexed_nearest_upscaler_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // tdata: palette_slot, red, green, blue, src_address, color_index, disp_x, disp_y
  input  wire logic [inu_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: req_type
  input  wire logic [inu_pkg::REQ_W-1:0]         in_tuser,
  // Result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // tdata: argb
  output logic      [inu_pkg::ARGB_W-1:0]        out_tdata,
  // tuser: in_picture
  output logic                                   out_tuser,
  // Configuration port
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [inu_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [inu_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [inu_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int Q  = inu_pkg::DIV_STEPS;
  localparam int DW = inu_pkg::DIV_DW;
  localparam int CW = inu_pkg::COORD_W;

  // Clamp display to its maximum, inset to the display, center the inset
  function automatic inu_pkg::axis_cfg_t place_axis(
    input logic [CW-1:0] disp,
    input logic [CW-1:0] inset,
    input int            max_disp
  );
    logic [CW-1:0]      d;
    logic [CW-1:0]      w;
    inu_pkg::axis_cfg_t a;
    d    = (32'(disp) > max_disp) ? CW'(max_disp) : disp;
    w    = (inset > d) ? d : inset;
    a.off = (d - w) >> 1;
    a.w   = w;
    a.nz  = (w != '0);
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CW-1:0] disp_w_r, disp_h_r, inset_w_r, inset_h_r;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_w_r  <= inu_pkg::RST_DISP_W;
      disp_h_r  <= inu_pkg::RST_DISP_H;
      inset_w_r <= inu_pkg::RST_INSET_W;
      inset_h_r <= inu_pkg::RST_INSET_H;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        inu_pkg::REG_DISP_W:  disp_w_r  <= cfg_pwdata[CW-1:0];
        inu_pkg::REG_DISP_H:  disp_h_r  <= cfg_pwdata[CW-1:0];
        inu_pkg::REG_INSET_W: inset_w_r <= cfg_pwdata[CW-1:0];
        inu_pkg::REG_INSET_H: inset_h_r <= cfg_pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      inu_pkg::REG_DISP_W:  cfg_prdata = inu_pkg::CFG_DATA_W'(disp_w_r);
      inu_pkg::REG_DISP_H:  cfg_prdata = inu_pkg::CFG_DATA_W'(disp_h_r);
      inu_pkg::REG_INSET_W: cfg_prdata = inu_pkg::CFG_DATA_W'(inset_w_r);
      inu_pkg::REG_INSET_H: cfg_prdata = inu_pkg::CFG_DATA_W'(inset_h_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // Rectangle placement, a registered copy derived from the registers; the
  // rectangle test and every divider stage read this copy.
  inu_pkg::axis_cfg_t x_cfg_r, y_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_cfg_r <= place_axis(inu_pkg::RST_DISP_W, inu_pkg::RST_INSET_W,
                            inu_pkg::MAX_DISPLAY_W);
      y_cfg_r <= place_axis(inu_pkg::RST_DISP_H, inu_pkg::RST_INSET_H,
                            inu_pkg::MAX_DISPLAY_H);
    end else begin
      x_cfg_r <= place_axis(disp_w_r, inset_w_r, inu_pkg::MAX_DISPLAY_W);
      y_cfg_r <= place_axis(disp_h_r, inset_h_r, inu_pkg::MAX_DISPLAY_H);
    end
  end

  // ---------------------------------------------------------------------------
  // Input acceptance and read credit
  // ---------------------------------------------------------------------------
  logic                     in_fire, out_fire, rd_fire;
  logic [inu_pkg::FIFO_AW:0] occ_r, occ_nxt;

  assign in_fire  = in_tvalid & in_tready;
  assign out_fire = out_tvalid & out_tready;
  assign rd_fire  = in_fire & (in_tuser == inu_pkg::REQ_READ);

  // Count reads accepted and not yet delivered; the output queue holds them all
  assign in_tready = (occ_r != (inu_pkg::FIFO_AW + 1)'(inu_pkg::FIFO_DEPTH));

  always_comb begin
    occ_nxt = occ_r;
    if (rd_fire && !out_fire) begin
      occ_nxt = occ_r + 1'b1;
    end else if (!rd_fire && out_fire) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: capture the beat; drop unknown kinds
  // ---------------------------------------------------------------------------
  inu_pkg::in_beat_t p1_r;
  logic              p1_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= in_fire & (in_tuser == inu_pkg::REQ_PAL_WR ||
                             in_tuser == inu_pkg::REQ_PIX_WR ||
                             in_tuser == inu_pkg::REQ_READ);
    end
    p1_r.kind <= in_tuser;
    p1_r.data <= inu_pkg::in_data_t'(in_tdata);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: rectangle test and offset inside the rectangle
  // ---------------------------------------------------------------------------
  inu_pkg::ctl_t p2_ctl_nxt, p2_ctl_r;
  logic [CW-1:0] rel_x, rel_y, rel_x_r, rel_y_r;
  logic          in_x, in_y;
  logic          p2_vld_r;

  always_comb begin
    rel_x = p1_r.data.disp_x - x_cfg_r.off;
    rel_y = p1_r.data.disp_y - y_cfg_r.off;
    in_x  = x_cfg_r.nz && (p1_r.data.disp_x >= x_cfg_r.off) && (rel_x < x_cfg_r.w);
    in_y  = y_cfg_r.nz && (p1_r.data.disp_y >= y_cfg_r.off) && (rel_y < y_cfg_r.w);

    p2_ctl_nxt.kind    = p1_r.kind;
    p2_ctl_nxt.in_rect = in_x & in_y;
    if (p1_r.kind == inu_pkg::REQ_PAL_WR) begin
      p2_ctl_nxt.waddr = inu_pkg::SRC_ADDR_W'(p1_r.data.palette_slot);
      p2_ctl_nxt.wdata = {p1_r.data.red, p1_r.data.green, p1_r.data.blue};
    end else begin
      p2_ctl_nxt.waddr = p1_r.data.src_address;
      p2_ctl_nxt.wdata = inu_pkg::RGB_W'(p1_r.data.color_index);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else begin
      p2_vld_r <= p1_vld_r;
    end
    p2_ctl_r <= p2_ctl_nxt;
    rel_x_r  <= rel_x;
    rel_y_r  <= rel_y;
  end

  // ---------------------------------------------------------------------------
  // Stage 3 and divider: (offset * source size) / inset size, one bit a stage
  // ---------------------------------------------------------------------------
  inu_pkg::div_t div_r     [Q+1];
  logic          div_vld_r [Q+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld_r[0] <= 1'b0;
    end else begin
      div_vld_r[0] <= p2_vld_r;
    end
    div_r[0].ctl   <= p2_ctl_r;
    div_r[0].rem_x <= DW'(rel_x_r) * DW'(inu_pkg::SRC_WIDTH);
    div_r[0].rem_y <= DW'(rel_y_r) * DW'(inu_pkg::SRC_HEIGHT);
    div_r[0].q_x   <= '0;
    div_r[0].q_y   <= '0;
  end

  for (genvar k = 0; k < Q; k++) begin : g_div
    localparam int B = Q - 1 - k;

    inu_pkg::div_t   step_nxt;
    logic [DW-1:0]   sub_x, sub_y;

    always_comb begin
      sub_x    = DW'(x_cfg_r.w) << B;
      sub_y    = DW'(y_cfg_r.w) << B;
      step_nxt = div_r[k];
      if (div_r[k].rem_x >= sub_x) begin
        step_nxt.rem_x  = div_r[k].rem_x - sub_x;
        step_nxt.q_x[B] = 1'b1;
      end
      if (div_r[k].rem_y >= sub_y) begin
        step_nxt.rem_y  = div_r[k].rem_y - sub_y;
        step_nxt.q_y[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_vld_r[k+1] <= 1'b0;
      end else begin
        div_vld_r[k+1] <= div_vld_r[k];
      end
      div_r[k+1] <= step_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: source frame address; frame memory access
  // ---------------------------------------------------------------------------
  inu_pkg::ctl_t               p4_ctl_r;
  logic [inu_pkg::FRAME_AW-1:0] p4_raddr_r;
  logic                        p4_vld_r;
  logic                        frame_we;
  logic [inu_pkg::IDX_W-1:0]   frame_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_vld_r <= 1'b0;
    end else begin
      p4_vld_r <= div_vld_r[Q];
    end
    p4_ctl_r   <= div_r[Q].ctl;
    p4_raddr_r <= inu_pkg::FRAME_AW'(32'(div_r[Q].q_y) * 32'(inu_pkg::SRC_WIDTH) +
                                     32'(div_r[Q].q_x));
  end

  // Drop pixel writes beyond the frame
  assign frame_we = p4_vld_r && (p4_ctl_r.kind == inu_pkg::REQ_PIX_WR) &&
                    (32'(p4_ctl_r.waddr) < inu_pkg::FRAME_SIZE);

  inu_ram #(
    .WIDTH (inu_pkg::IDX_W),
    .DEPTH (inu_pkg::FRAME_SIZE)
  ) u_frame (
    .clk   (clk),
    .we    (frame_we),
    .waddr (inu_pkg::FRAME_AW'(p4_ctl_r.waddr)),
    .wdata (p4_ctl_r.wdata[inu_pkg::IDX_W-1:0]),
    .raddr (p4_raddr_r),
    .rdata (frame_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 5: palette memory access with the fetched index
  // ---------------------------------------------------------------------------
  inu_pkg::ctl_t             p5_ctl_r;
  logic                      p5_vld_r;
  logic                      pal_we;
  logic [inu_pkg::RGB_W-1:0] pal_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_vld_r <= 1'b0;
    end else begin
      p5_vld_r <= p4_vld_r;
    end
    p5_ctl_r <= p4_ctl_r;
  end

  assign pal_we = p5_vld_r && (p5_ctl_r.kind == inu_pkg::REQ_PAL_WR);

  inu_ram #(
    .WIDTH (inu_pkg::RGB_W),
    .DEPTH (inu_pkg::PAL_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (p5_ctl_r.waddr[inu_pkg::PAL_AW-1:0]),
    .wdata (p5_ctl_r.wdata),
    .raddr (frame_rdata[inu_pkg::PAL_AW-1:0]),
    .rdata (pal_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 6: form the result of a read
  // ---------------------------------------------------------------------------
  logic            p6_vld_r, p6_inside_r;
  inu_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_vld_r <= 1'b0;
    end else begin
      p6_vld_r <= p5_vld_r && (p5_ctl_r.kind == inu_pkg::REQ_READ);
    end
    p6_inside_r <= p5_ctl_r.in_rect;
  end

  always_comb begin
    res.in_picture = p6_inside_r;
    res.argb       = p6_inside_r ? {inu_pkg::OPAQUE_ALPHA, pal_rdata} : '0;
  end

  // ---------------------------------------------------------------------------
  // Output queue; the read credit keeps it from overflowing
  // ---------------------------------------------------------------------------
  inu_pkg::result_t          fifo_r [inu_pkg::FIFO_DEPTH];
  logic [inu_pkg::FIFO_AW:0] wr_ptr_r, rd_ptr_r;
  inu_pkg::result_t          head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (p6_vld_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
    if (p6_vld_r) begin
      fifo_r[wr_ptr_r[inu_pkg::FIFO_AW-1:0]] <= res;
    end
  end

  assign head       = fifo_r[rd_ptr_r[inu_pkg::FIFO_AW-1:0]];
  assign out_tvalid = (wr_ptr_r != rd_ptr_r);
  assign out_tdata  = head.argb;
  assign out_tuser  = head.in_picture;

endmodule

`default_nettype wire
